>>> hw/rtl/cleb_pkg.sv
package cleb_pkg;

  localparam int BUF_DEPTH_DEF = 128;

  // Key codes
  localparam logic [7:0] KEY_NUL   = 8'h00;
  localparam logic [7:0] KEY_EOT   = 8'h04;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_LF    = 8'h0a;
  localparam logic [7:0] KEY_CR    = 8'h0d;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_DEL   = 8'h7f;

  // Request codes
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;
  localparam logic [1:0] KIND_EOF   = 2'd3;

  // Datapath -> controller
  typedef struct packed {
    logic is_read;  // request is a read
    logic silent;   // key request that yields no result
    logic is_bs;    // key request is a backspace that deletes
  } cleb_status_t;

  // Controller -> datapath
  typedef struct packed {
    logic ld_key;      // apply a key and load its first echo
    logic take_read;   // latch read request fields
    logic ld_read;     // resolve read against store data
    logic ld_space;    // load the space of a backspace echo
    logic ld_bs_last;  // load the closing BS of a backspace echo
  } cleb_cmd_t;

endpackage

>>> hw/rtl/cleb_in_if.sv
interface cleb_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] key_code;
  logic       first_of_read;

  modport source (output valid, output cmd, output key_code, output first_of_read,
                  input ready);
  modport sink   (input valid, input cmd, input key_code, input first_of_read,
                  output ready);
endinterface

>>> hw/rtl/cleb_out_if.sv
interface cleb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output kind, output data_byte, output last,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input last,
                  output ready);
endinterface

>>> hw/rtl/cleb_ctrl.sv
module cleb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  cleb_pkg::cleb_status_t status,
  output cleb_pkg::cleb_cmd_t    cmd
);
  import cleb_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] beats_r, beats_nxt;  // echo beats still to come after the shown one
  logic       in_acc, out_acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;

  always_comb begin
    cmd.ld_key     = in_acc & ~status.is_read & ~status.silent;
    cmd.take_read  = in_acc & status.is_read;
    cmd.ld_read    = (state_r == ST_READ);
    cmd.ld_space   = out_acc & (beats_r == 2'd2);
    cmd.ld_bs_last = out_acc & (beats_r == 2'd1);
  end

  always_comb begin
    state_nxt = state_r;
    beats_nxt = beats_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (status.is_read) begin
            state_nxt = ST_READ;
          end else if (!status.silent) begin
            state_nxt = ST_SEND;
            beats_nxt = status.is_bs ? 2'd2 : 2'd0;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_SEND;
        beats_nxt = 2'd0;
      end
      ST_SEND: begin
        if (out_acc) begin
          if (beats_r == 2'd0) begin
            state_nxt = ST_IDLE;
          end else begin
            beats_nxt = beats_r - 2'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      beats_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      beats_r <= beats_nxt;
    end
  end

endmodule

>>> hw/rtl/cleb_dpath.sv
module cleb_dpath #(
  parameter int BUF_DEPTH = cleb_pkg::BUF_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_cmd,
  input  logic [7:0]            in_key_code,
  input  logic                  in_first_of_read,
  input  cleb_pkg::cleb_cmd_t    cmd,
  output cleb_pkg::cleb_status_t status,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_data_byte,
  output logic                  out_last
);
  import cleb_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(BUF_DEPTH - 1);

  // Each index is a slot plus a lap bit: together they count modulo 2*BUF_DEPTH.
  logic [AW-1:0] edit_slot_r, commit_slot_r, read_slot_r;
  logic          edit_lap_r, commit_lap_r, read_lap_r;

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_r;
  logic       first_r;

  logic [1:0] kind_r;
  logic [7:0] data_r;
  logic       last_r;

  logic          key_is_bs, nothing_open, ring_full, key_store;
  logic [7:0]    key_mapped;
  logic [AW-1:0] edit_inc_slot, edit_dec_slot, read_inc_slot;
  logic          edit_inc_lap, edit_dec_lap, read_inc_lap;
  logic          full_after, commit_now, read_empty;

  always_comb begin
    edit_inc_slot = (edit_slot_r == LAST_SLOT) ? '0 : edit_slot_r + 1'b1;
    edit_inc_lap  = (edit_slot_r == LAST_SLOT) ? ~edit_lap_r : edit_lap_r;
    edit_dec_slot = (edit_slot_r == '0) ? LAST_SLOT : edit_slot_r - 1'b1;
    edit_dec_lap  = (edit_slot_r == '0) ? ~edit_lap_r : edit_lap_r;
    read_inc_slot = (read_slot_r == LAST_SLOT) ? '0 : read_slot_r + 1'b1;
    read_inc_lap  = (read_slot_r == LAST_SLOT) ? ~read_lap_r : read_lap_r;
  end

  always_comb begin
    key_is_bs    = (in_key_code == KEY_BS) || (in_key_code == KEY_DEL);
    nothing_open = (edit_slot_r == commit_slot_r) && (edit_lap_r == commit_lap_r);
    ring_full    = (edit_slot_r == read_slot_r) && (edit_lap_r != read_lap_r);
    key_mapped   = (in_key_code == KEY_CR) ? KEY_LF : in_key_code;
    key_store    = ~key_is_bs;
    full_after   = (edit_inc_slot == read_slot_r) && (edit_inc_lap != read_lap_r);
    commit_now   = (key_mapped == KEY_LF) || (key_mapped == KEY_EOT) || full_after;
    read_empty   = (read_slot_r == commit_slot_r) && (read_lap_r == commit_lap_r);

    status.is_read = (in_cmd == CMD_READ);
    status.is_bs   = key_is_bs;
    status.silent  = (in_cmd == CMD_KEY) &&
                     ((key_is_bs && nothing_open) ||
                      (!key_is_bs && (in_key_code == KEY_NUL)) ||
                      (!key_is_bs && ring_full));
  end

  // Line store: one write port, one registered read port at the read slot.
  always_ff @(posedge clk) begin
    if (cmd.ld_key && key_store) begin
      mem[edit_slot_r] <= key_mapped;
    end
    rd_data_r <= mem[read_slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_slot_r   <= '0;
      edit_lap_r    <= 1'b0;
      commit_slot_r <= '0;
      commit_lap_r  <= 1'b0;
      read_slot_r   <= '0;
      read_lap_r    <= 1'b0;
    end else begin
      if (cmd.ld_key) begin
        if (key_store) begin
          edit_slot_r <= edit_inc_slot;
          edit_lap_r  <= edit_inc_lap;
          if (commit_now) begin
            commit_slot_r <= edit_inc_slot;
            commit_lap_r  <= edit_inc_lap;
          end
        end else begin
          edit_slot_r <= edit_dec_slot;
          edit_lap_r  <= edit_dec_lap;
        end
      end
      if (cmd.ld_read && !read_empty &&
          ((rd_data_r != KEY_EOT) || first_r)) begin
        read_slot_r <= read_inc_slot;
        read_lap_r  <= read_inc_lap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_read) begin
      first_r <= in_first_of_read;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.ld_key) begin
      kind_r <= KIND_ECHO;
      data_r <= key_store ? key_mapped : KEY_BS;
      last_r <= key_store;
    end else if (cmd.ld_read) begin
      last_r <= 1'b1;
      if (read_empty) begin
        kind_r <= KIND_EMPTY;
        data_r <= 8'h00;
      end else if (rd_data_r == KEY_EOT) begin
        kind_r <= KIND_EOF;
        data_r <= 8'h00;
      end else begin
        kind_r <= KIND_DATA;
        data_r <= rd_data_r;
      end
    end else if (cmd.ld_space) begin
      kind_r <= KIND_ECHO;
      data_r <= KEY_SPACE;
      last_r <= 1'b0;
    end else if (cmd.ld_bs_last) begin
      kind_r <= KIND_ECHO;
      data_r <= KEY_BS;
      last_r <= 1'b1;
    end
  end

  assign out_kind      = kind_r;
  assign out_data_byte = data_r;
  assign out_last      = last_r;

endmodule

>>> hw/rtl/console_line_edit_buffer_unit.sv
// Console line edit buffer: canonical input line editing for a serial console.
// in_ch carries requests: cmd 0 is a key from the UART (key_code), cmd 1 asks
// for one committed byte (first_of_read marks the first byte of a read call).
// out_ch returns results: echo bytes, read data, empty or end of file; last
// marks the final beat caused by one request.
// Keys are echoed in the cycle after acceptance; a deleting backspace gives
// three echo beats (BS, space, BS). A read waits in ST_READ, then loads its
// single beat into the result register, since the line store is read through
// a registered port. One request is worked at a time. Ignored keys (zero, a
// backspace with nothing to delete, a key into a full ring) give no beat and
// leave in_ch ready. Reset empties the ring by zeroing its read, commit and
// edit indices; the store itself is not cleared. When the receiver stalls,
// the pending beat holds on out_ch and in_ch stays not ready until every
// beat is taken.
module console_line_edit_buffer_unit #(
  parameter int BUF_DEPTH = cleb_pkg::BUF_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  cleb_in_if.sink   in_ch,
  cleb_out_if.source out_ch
);
  import cleb_pkg::*;

  cleb_status_t status;
  cleb_cmd_t    cmd;

  // Sequence the request: accept, wait for store data, present beats.
  cleb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the ring, its indices and the result register.
  cleb_dpath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_cmd           (in_ch.cmd),
    .in_key_code      (in_ch.key_code),
    .in_first_of_read (in_ch.first_of_read),
    .cmd              (cmd),
    .status           (status),
    .out_kind         (out_ch.kind),
    .out_data_byte    (out_ch.data_byte),
    .out_last         (out_ch.last)
  );

endmodule
